// ===== hw/rtl/psrp_pkg.sv =====
// ----------------------------------------------------------------------------
// psrp_pkg
// Types, field codes and the field order table shared by the sample record
// parser modules.
// ----------------------------------------------------------------------------
package psrp_pkg;

  localparam int MASK_W = 17;

  // Word counts of the fixed-length runs
  localparam logic [63:0] USER_REG_COUNT = 64'd20;
  localparam logic [63:0] READ_WORDS     = 64'd1;

  // Register ABI value for 64-bit user registers
  localparam logic [63:0] ABI_64 = 64'd2;

  // Field codes; the parse phase uses the same encoding
  localparam logic [4:0] CODE_HEADER     = 5'd0;
  localparam logic [4:0] CODE_IDENTIFIER = 5'd1;
  localparam logic [4:0] CODE_IP         = 5'd2;
  localparam logic [4:0] CODE_PID_TID    = 5'd3;
  localparam logic [4:0] CODE_TIME       = 5'd4;
  localparam logic [4:0] CODE_ADDR       = 5'd5;
  localparam logic [4:0] CODE_ID         = 5'd6;
  localparam logic [4:0] CODE_STREAM_ID  = 5'd7;
  localparam logic [4:0] CODE_CPU_RES    = 5'd8;
  localparam logic [4:0] CODE_PERIOD     = 5'd9;
  localparam logic [4:0] CODE_READ       = 5'd10;
  localparam logic [4:0] CODE_CHAIN_N    = 5'd11;
  localparam logic [4:0] CODE_CHAIN_IP   = 5'd12;
  localparam logic [4:0] CODE_RAW_FIRST  = 5'd13;
  localparam logic [4:0] CODE_RAW_DATA   = 5'd14;
  localparam logic [4:0] CODE_ABI        = 5'd15;
  localparam logic [4:0] CODE_USER_REG   = 5'd16;
  localparam logic [4:0] CODE_STK_SIZE   = 5'd17;
  localparam logic [4:0] CODE_STK_DATA   = 5'd18;
  localparam logic [4:0] CODE_DYN_SIZE   = 5'd19;
  localparam logic [4:0] CODE_TRAILING   = 5'd20;
  localparam logic [4:0] CODE_REJECTED   = 5'd21;

  // Optional fields in record order, with the mask bit that selects each
  localparam int NUM_ENTRY = 14;
  localparam logic [4:0] ENTRY_CODE [NUM_ENTRY] = '{
    CODE_IDENTIFIER, CODE_IP, CODE_PID_TID, CODE_TIME, CODE_ADDR, CODE_ID,
    CODE_STREAM_ID, CODE_CPU_RES, CODE_PERIOD, CODE_READ, CODE_CHAIN_N,
    CODE_RAW_FIRST, CODE_ABI, CODE_STK_SIZE
  };
  localparam logic [4:0] ENTRY_BIT [NUM_ENTRY] = '{
    5'd16, 5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd9,
    5'd7, 5'd8, 5'd4, 5'd5, 5'd10, 5'd12, 5'd13
  };

  typedef struct packed {
    logic [63:0] record_word;
    logic        record_start;
  } psrp_in_t;

  typedef struct packed {
    logic [4:0]  field_code;
    logic [63:0] field_value;
    logic [15:0] element_index;
    logic [63:0] stack_effective_size;
    logic        abi_error;
  } psrp_out_t;

  // Input register towards the tagger
  typedef struct packed {
    logic     valid;
    psrp_in_t item;
  } psrp_stage_t;

  // First enabled field whose code lies above the given one
  function automatic logic [4:0] next_field(input logic [4:0]        after,
                                            input logic [MASK_W-1:0] mask);
    logic [4:0] nxt;
    logic       found;
    nxt   = CODE_TRAILING;
    found = 1'b0;
    for (int i = 0; i < NUM_ENTRY; i++) begin
      if (!found && (ENTRY_CODE[i] > after) && mask[ENTRY_BIT[i]]) begin
        nxt   = ENTRY_CODE[i];
        found = 1'b1;
      end
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/psrp_in_stage.sv =====
// ----------------------------------------------------------------------------
// psrp_in_stage
// Input register: captures one word per transfer and holds it until the
// tagger takes it.
// ----------------------------------------------------------------------------
module psrp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psrp_pkg::psrp_in_t in_data,
  output psrp_pkg::psrp_stage_t stage,
  input  logic               take
);

  logic               valid_r;
  logic               valid_nxt;
  psrp_pkg::psrp_in_t item_r;
  logic               accept;

  // Refill in the same cycle the held word moves on
  assign in_stall  = valid_r && !take;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== hw/rtl/psrp_tagger.sv =====
// ----------------------------------------------------------------------------
// psrp_tagger
// Parse state, per-word field tagging and the result register.
// ----------------------------------------------------------------------------
module psrp_tagger (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psrp_pkg::MASK_W-1:0]   cfg_wdata,
  input  psrp_pkg::psrp_stage_t         stage,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psrp_pkg::psrp_out_t           out_data
);

  logic [psrp_pkg::MASK_W-1:0] mask_r;
  logic [4:0]                  phase_r, phase_nxt;
  logic [63:0]                 remain_r, remain_nxt;
  logic [15:0]                 run_idx_r, run_idx_nxt;
  logic [63:0]                 stk_size_r, stk_size_nxt;
  logic                        out_valid_r;
  psrp_pkg::psrp_out_t         out_data_r;
  psrp_pkg::psrp_out_t         res;

  logic [63:0] w;
  logic [63:0] remain_dec;
  logic [15:0] run_idx_inc;
  logic [15:0] idle_base;
  logic [63:0] stk_words;
  logic        do_enter;
  logic [4:0]  enter_from;
  logic [4:0]  entered;

  assign take = stage.valid && (!out_valid_r || !out_stall);
  assign w    = stage.item.record_word;

  assign remain_dec  = (remain_r != 64'd0) ? (remain_r - 64'd1) : 64'd0;
  assign run_idx_inc = (run_idx_r != 16'hFFFF) ? (run_idx_r + 16'd1) : run_idx_r;
  assign stk_words   = {3'b000, w[63:3]} + {63'd0, (w[2:0] != 3'd0)};
  assign entered     = psrp_pkg::next_field(enter_from, mask_r);

  always_comb begin
    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    run_idx_nxt  = run_idx_r;
    stk_size_nxt = stk_size_r;
    do_enter     = 1'b0;
    enter_from   = phase_r;
    idle_base    = run_idx_r;

    res.field_code           = phase_r;
    res.field_value          = w;
    res.element_index        = 16'd0;
    res.stack_effective_size = 64'd0;
    res.abi_error            = 1'b0;

    if (stage.item.record_start) begin
      res.field_code = psrp_pkg::CODE_HEADER;
      stk_size_nxt   = 64'd0;
      remain_nxt     = 64'd0;
      do_enter       = 1'b1;
      enter_from     = psrp_pkg::CODE_HEADER;
    end else if (phase_r == psrp_pkg::CODE_HEADER || phase_r >= psrp_pkg::CODE_TRAILING) begin
      // No header seen yet counts as trailing; restart the run there
      if (phase_r != psrp_pkg::CODE_TRAILING && phase_r != psrp_pkg::CODE_REJECTED) begin
        idle_base      = 16'd0;
        phase_nxt      = psrp_pkg::CODE_TRAILING;
        res.field_code = psrp_pkg::CODE_TRAILING;
      end
      res.element_index = idle_base;
      run_idx_nxt       = (idle_base != 16'hFFFF) ? (idle_base + 16'd1) : idle_base;
    end else if (phase_r inside {psrp_pkg::CODE_READ, psrp_pkg::CODE_CHAIN_IP,
                                 psrp_pkg::CODE_RAW_DATA, psrp_pkg::CODE_USER_REG,
                                 psrp_pkg::CODE_STK_DATA}) begin
      res.element_index = run_idx_r;
      run_idx_nxt       = run_idx_inc;
      remain_nxt        = remain_dec;
      if (remain_dec == 64'd0) begin
        if (phase_r == psrp_pkg::CODE_STK_DATA) begin
          phase_nxt   = psrp_pkg::CODE_DYN_SIZE;
          run_idx_nxt = 16'd0;
        end else begin
          do_enter = 1'b1;
        end
      end
    end else begin
      case (phase_r)
        psrp_pkg::CODE_CHAIN_N: begin
          if (w == 64'd0) begin
            do_enter   = 1'b1;
            enter_from = psrp_pkg::CODE_CHAIN_IP;
          end else begin
            phase_nxt   = psrp_pkg::CODE_CHAIN_IP;
            remain_nxt  = w;
            run_idx_nxt = 16'd0;
          end
        end
        psrp_pkg::CODE_RAW_FIRST: begin
          if (w[31:3] == 29'd0) begin
            do_enter   = 1'b1;
            enter_from = psrp_pkg::CODE_RAW_DATA;
          end else begin
            phase_nxt   = psrp_pkg::CODE_RAW_DATA;
            remain_nxt  = {35'd0, w[31:3]};
            run_idx_nxt = 16'd0;
          end
        end
        psrp_pkg::CODE_ABI: begin
          if (w != psrp_pkg::ABI_64) begin
            res.abi_error = 1'b1;
            phase_nxt     = psrp_pkg::CODE_REJECTED;
            run_idx_nxt   = 16'd0;
          end else begin
            phase_nxt   = psrp_pkg::CODE_USER_REG;
            remain_nxt  = psrp_pkg::USER_REG_COUNT;
            run_idx_nxt = 16'd0;
          end
        end
        psrp_pkg::CODE_STK_SIZE: begin
          stk_size_nxt = w;
          if (stk_words == 64'd0) begin
            do_enter   = 1'b1;
            enter_from = psrp_pkg::CODE_DYN_SIZE;
          end else begin
            phase_nxt   = psrp_pkg::CODE_STK_DATA;
            remain_nxt  = stk_words;
            run_idx_nxt = 16'd0;
          end
        end
        psrp_pkg::CODE_DYN_SIZE: begin
          res.stack_effective_size = (stk_size_r < w) ? 64'd0 : w;
          do_enter                 = 1'b1;
        end
        default: begin
          // Single-word fields: advance to the next enabled one
          do_enter = 1'b1;
        end
      endcase
    end

    if (do_enter) begin
      phase_nxt   = entered;
      run_idx_nxt = 16'd0;
      if (entered == psrp_pkg::CODE_READ) begin
        remain_nxt = psrp_pkg::READ_WORDS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      phase_r     <= psrp_pkg::CODE_HEADER;
      remain_r    <= 64'd0;
      run_idx_r   <= 16'd0;
      stk_size_r  <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (take) begin
        phase_r    <= phase_nxt;
        remain_r   <= remain_nxt;
        run_idx_r  <= run_idx_nxt;
        stk_size_r <= stk_size_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/perf_sample_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// perf_sample_record_parser_unit
// Tags each 64-bit word of a perf sample record with the field it holds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one record word per
//   transfer; record_start marks the header word and restarts parsing.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   tagged word per input word, in order: field code, the word itself, the
//   index inside its run, the effective stack size on the dynamic-size word
//   and the ABI error flag.
//   cfg_we / cfg_wdata write the 17-bit sample type mask; write it only while
//   no words are in flight.
//   The word is captured in the input register and then tagged into the
//   result register, which drives out_valid and out_data. Throughput is
//   one word per cycle while out_stall stays low, set by the phase update
//   in the tagger.
//   Synchronous reset clears the mask, the parse phase (header expected) and
//   both valid flags. While the receiver stalls, the result is held and the
//   input register, if empty, can still take one more word before in_stall
//   rises.
// ----------------------------------------------------------------------------
module perf_sample_record_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  psrp_pkg::psrp_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output psrp_pkg::psrp_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [psrp_pkg::MASK_W-1:0] cfg_wdata
);

  psrp_pkg::psrp_stage_t stage;
  logic                  take;

  psrp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .stage    (stage),
    .take     (take)
  );

  psrp_tagger u_tagger (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/psrp_checker.sv =====
// ----------------------------------------------------------------------------
// psrp_checker
// Port-level checks for the sample record parser, bound to the top level.
// ----------------------------------------------------------------------------
module psrp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input psrp_pkg::psrp_out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_abi_err_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.abi_error |-> out_data.field_code == psrp_pkg::CODE_ABI)
    else $error("ABI error flagged on a word that is not the ABI word");

  a_eff_size_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.stack_effective_size != 64'd0)
      |-> out_data.field_code == psrp_pkg::CODE_DYN_SIZE)
    else $error("effective stack size set outside the dynamic-size word");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.field_code <= psrp_pkg::CODE_REJECTED)
    else $error("field code out of range");

endmodule

bind perf_sample_record_parser_unit psrp_checker u_psrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
